FILE: hw/rtl/tfvs_pkg.sv
`default_nettype none

package tfvs_pkg;

    // request function codes
    localparam logic [1:0] FUNC_FRAME  = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LOW_VOLT  = 2'd0;
    localparam logic [1:0] CFG_TEMP_MIN  = 2'd1;
    localparam logic [1:0] CFG_TEMP_MAX  = 2'd2;
    localparam logic [1:0] CFG_FRM_LIMIT = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [14:0]        LOW_VOLT_RST  = 15'd2200;
    localparam logic signed [15:0] TEMP_MIN_RST  = -16'sd400;
    localparam logic signed [15:0] TEMP_MAX_RST  = 16'sd1200;
    localparam logic [15:0]        FRM_LIMIT_RST = 16'hFFFF;

    // frames-per-second scaling on millisecond timestamps
    localparam logic [9:0] RATE_SCALE = 10'd1000;

    // shared divider width and its step counter width
    localparam int DIV_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIME      = 3'd1,
        ST_SEQ       = 3'd2,
        ST_VOLT      = 3'd3,
        ST_TEMP      = 3'd4,
        ST_GPS       = 3'd5,
        ST_SATS      = 3'd6,
        ST_NO_FRAMES = 3'd7
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic frame;
        logic clear;
        logic start_avg;
        logic start_rate;
        logic cap_avg;
        logic cap_rate;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic err_set;
        logic no_frames;
        logic elapsed_zero;
        logic div_done;
    } sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tfvs_if.sv
`default_nettype none

interface tfvs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [31:0]        stamp_ms;
    logic [30:0]        seq_num;
    logic signed [15:0] voltage_cv;
    logic signed [15:0] temperature_dc;
    logic signed [7:0]  gps_fix;
    logic signed [7:0]  satellites;

    modport source (
        output valid, func, stamp_ms, seq_num, voltage_cv, temperature_dc,
               gps_fix, satellites,
        input  ready
    );
    modport sink (
        input  valid, func, stamp_ms, seq_num, voltage_cv, temperature_dc,
               gps_fix, satellites,
        output ready
    );
endinterface

interface tfvs_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [15:0]        good_frames;
    logic signed [15:0] voltage_min_cv;
    logic signed [15:0] voltage_max_cv;
    logic signed [15:0] temperature_avg_dc;
    logic [15:0]        low_voltage_count;
    logic [9:0]         rate_fps;

    modport source (
        output valid, status, good_frames, voltage_min_cv, voltage_max_cv,
               temperature_avg_dc, low_voltage_count, rate_fps,
        input  ready
    );
    modport sink (
        input  valid, status, good_frames, voltage_min_cv, voltage_max_cv,
               temperature_avg_dc, low_voltage_count, rate_fps,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/tfvs_divider.sv
`default_nettype none

// restoring unsigned divider, one quotient bit per cycle
module tfvs_divider (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [tfvs_pkg::DIV_W-1:0] dividend,
    input  wire logic [tfvs_pkg::DIV_W-1:0] divisor,
    output logic                          done,
    output logic [tfvs_pkg::DIV_W-1:0]    quotient
);

    localparam int W = tfvs_pkg::DIV_W;
    localparam int CW = tfvs_pkg::DIV_CNT_W;

    logic [W-1:0]  dvd_reg;   // dividend bits shift out, quotient bits shift in
    logic [W-1:0]  dsr_reg;
    logic [W-1:0]  rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          q_bit;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        diff  = trial - {1'b0, dsr_reg};
        q_bit = (trial >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[W-2:0], q_bit};
            rem_reg <= q_bit ? diff[W-1:0] : trial[W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tfvs_datapath.sv
`default_nettype none

module tfvs_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [tfvs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tfvs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire tfvs_pkg::cmd_t                 cmd,
    output tfvs_pkg::sts_t                      sts,
    tfvs_in_if.sink                             in_ch,
    tfvs_out_if.source                          out_ch
);

    // configuration
    logic [14:0]        low_volt_reg;
    logic signed [15:0] temp_min_reg;
    logic signed [15:0] temp_max_reg;
    logic [15:0]        frm_limit_reg;

    // statistics
    tfvs_pkg::status_t  err_reg;
    logic [15:0]        count_reg;
    logic [31:0]        first_time_reg;
    logic [31:0]        last_time_reg;
    logic [30:0]        last_seq_reg;
    logic signed [15:0] vmin_reg;
    logic signed [15:0] vmax_reg;
    logic signed [32:0] tsum_reg;
    logic [15:0]        low_cnt_reg;

    // report results
    logic               avg_neg_reg;
    logic [15:0]        avg_reg;
    logic [9:0]         rate_reg;

    // output register
    logic [2:0]         o_status_reg;
    logic [15:0]        o_total_reg;
    logic [15:0]        o_vmin_reg;
    logic [15:0]        o_vmax_reg;
    logic [15:0]        o_avg_reg;
    logic [15:0]        o_low_reg;
    logic [9:0]         o_rate_reg;

    tfvs_pkg::status_t  chk;
    logic               has_frames;
    logic [32:0]        tsum_abs;
    logic [15:0]        cnt_m1;
    logic [25:0]        rate_num;
    logic [31:0]        elapsed;
    logic               div_start;
    logic [tfvs_pkg::DIV_W-1:0] div_dvd;
    logic [tfvs_pkg::DIV_W-1:0] div_dsr;
    logic               div_done;
    logic [tfvs_pkg::DIV_W-1:0] div_q;
    tfvs_pkg::status_t  rep_status;

    assign has_frames = (count_reg != 16'd0);

    // frame checks in priority order
    always_comb
    begin
        if (has_frames && (in_ch.stamp_ms <= last_time_reg))
            chk = tfvs_pkg::ST_TIME;
        else if (has_frames && (in_ch.seq_num != last_seq_reg + 31'd1))
            chk = tfvs_pkg::ST_SEQ;
        else if (in_ch.voltage_cv < 16'sd0)
            chk = tfvs_pkg::ST_VOLT;
        else if ((in_ch.temperature_dc < temp_min_reg)
                 || (in_ch.temperature_dc > temp_max_reg))
            chk = tfvs_pkg::ST_TEMP;
        else if ((in_ch.gps_fix != 8'sd0) && (in_ch.gps_fix != 8'sd1))
            chk = tfvs_pkg::ST_GPS;
        else if (in_ch.satellites < 8'sd0)
            chk = tfvs_pkg::ST_SATS;
        else
            chk = tfvs_pkg::ST_OK;
    end

    // divider operands
    always_comb
    begin
        tsum_abs  = tsum_reg[32] ? (33'd0 - 33'(tsum_reg)) : 33'(tsum_reg);
        cnt_m1    = count_reg - 16'd1;
        rate_num  = 26'(cnt_m1) * 26'(tfvs_pkg::RATE_SCALE);
        elapsed   = last_time_reg - first_time_reg;
        div_start = cmd.start_avg || cmd.start_rate;
        if (cmd.start_rate)
        begin
            div_dvd = tfvs_pkg::DIV_W'(rate_num);
            div_dsr = elapsed;
        end
        else
        begin
            div_dvd = tsum_abs[tfvs_pkg::DIV_W-1:0];
            div_dsr = tfvs_pkg::DIV_W'(count_reg);
        end
    end

    tfvs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_volt_reg  <= tfvs_pkg::LOW_VOLT_RST;
            temp_min_reg  <= tfvs_pkg::TEMP_MIN_RST;
            temp_max_reg  <= tfvs_pkg::TEMP_MAX_RST;
            frm_limit_reg <= tfvs_pkg::FRM_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tfvs_pkg::CFG_LOW_VOLT:  low_volt_reg  <= cfg_data[14:0];
                tfvs_pkg::CFG_TEMP_MIN:  temp_min_reg  <= $signed(cfg_data);
                tfvs_pkg::CFG_TEMP_MAX:  temp_max_reg  <= $signed(cfg_data);
                tfvs_pkg::CFG_FRM_LIMIT: frm_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg        <= tfvs_pkg::ST_OK;
            count_reg      <= '0;
            first_time_reg <= '0;
            last_time_reg  <= '0;
            last_seq_reg   <= '0;
            vmin_reg       <= '0;
            vmax_reg       <= '0;
            tsum_reg       <= '0;
            low_cnt_reg    <= '0;
        end
        else if (cmd.clear)
        begin
            err_reg        <= tfvs_pkg::ST_OK;
            count_reg      <= '0;
            first_time_reg <= '0;
            last_time_reg  <= '0;
            last_seq_reg   <= '0;
            vmin_reg       <= '0;
            vmax_reg       <= '0;
            tsum_reg       <= '0;
            low_cnt_reg    <= '0;
        end
        else if (cmd.frame && (err_reg == tfvs_pkg::ST_OK)
                 && (count_reg < frm_limit_reg))
        begin
            if (chk != tfvs_pkg::ST_OK)
            begin
                err_reg <= chk;
            end
            else
            begin
                if (!has_frames)
                begin
                    first_time_reg <= in_ch.stamp_ms;
                    vmin_reg       <= in_ch.voltage_cv;
                    vmax_reg       <= in_ch.voltage_cv;
                end
                else
                begin
                    if (in_ch.voltage_cv < vmin_reg)
                        vmin_reg <= in_ch.voltage_cv;
                    if (in_ch.voltage_cv > vmax_reg)
                        vmax_reg <= in_ch.voltage_cv;
                end
                last_time_reg <= in_ch.stamp_ms;
                last_seq_reg  <= in_ch.seq_num;
                tsum_reg      <= tsum_reg + 33'(in_ch.temperature_dc);
                if (in_ch.voltage_cv < $signed({1'b0, low_volt_reg}))
                    low_cnt_reg <= low_cnt_reg + 16'd1;
                count_reg <= count_reg + 16'd1;
            end
        end
    end

    always_comb
    begin
        if (err_reg != tfvs_pkg::ST_OK)
            rep_status = err_reg;
        else if (!has_frames)
            rep_status = tfvs_pkg::ST_NO_FRAMES;
        else
            rep_status = tfvs_pkg::ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_avg)
            avg_neg_reg <= tsum_reg[32];
        if (cmd.cap_avg)
        begin
            avg_reg  <= avg_neg_reg ? (16'd0 - div_q[15:0]) : div_q[15:0];
            rate_reg <= '0;
        end
        if (cmd.cap_rate)
            rate_reg <= div_q[9:0];
        if (cmd.load_out)
        begin
            o_status_reg <= rep_status;
            if (rep_status == tfvs_pkg::ST_OK)
            begin
                o_total_reg <= count_reg;
                o_vmin_reg  <= vmin_reg;
                o_vmax_reg  <= vmax_reg;
                o_avg_reg   <= avg_reg;
                o_low_reg   <= low_cnt_reg;
                o_rate_reg  <= rate_reg;
            end
            else
            begin
                o_total_reg <= '0;
                o_vmin_reg  <= '0;
                o_vmax_reg  <= '0;
                o_avg_reg   <= '0;
                o_low_reg   <= '0;
                o_rate_reg  <= '0;
            end
        end
    end

    assign sts.err_set      = (err_reg != tfvs_pkg::ST_OK);
    assign sts.no_frames    = !has_frames;
    assign sts.elapsed_zero = (elapsed == 32'd0);
    assign sts.div_done     = div_done;

    assign out_ch.status             = o_status_reg;
    assign out_ch.good_frames        = o_total_reg;
    assign out_ch.voltage_min_cv     = $signed(o_vmin_reg);
    assign out_ch.voltage_max_cv     = $signed(o_vmax_reg);
    assign out_ch.temperature_avg_dc = $signed(o_avg_reg);
    assign out_ch.low_voltage_count  = o_low_reg;
    assign out_ch.rate_fps           = o_rate_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tfvs_ctrl.sv
`default_nettype none

module tfvs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [1:0]     in_func,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output tfvs_pkg::cmd_t      cmd,
    input  wire tfvs_pkg::sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_AVG,
        S_RATE,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   in_acc;
    logic   out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_func)
                        tfvs_pkg::FUNC_FRAME: cmd.frame = 1'b1;
                        tfvs_pkg::FUNC_CLEAR: cmd.clear = 1'b1;
                        tfvs_pkg::FUNC_REPORT:
                        begin
                            if (sts.err_set || sts.no_frames)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                cmd.start_avg = 1'b1;
                                state_next    = S_AVG;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_AVG:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_avg = 1'b1;
                    if (sts.elapsed_zero)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.start_rate = 1'b1;
                        state_next     = S_RATE;
                    end
                end
            end
            S_RATE:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_rate = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == S_AVG || state_reg == S_RATE))
        else $error("divider finished outside a division state");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result loaded over an unread result");

    a_avg_enter: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_avg |=> (state_reg == S_AVG && !cmd.load_out))
        else $error("average division not followed by its wait state");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

FILE: hw/rtl/telemetry_frame_validate_summarize.sv
`default_nettype none
// Frames and clears take effect at the accepting edge, one per cycle outside a report.
// Report: on error or empty log it goes straight to the finish state; with zero
// elapsed time only the average pass runs, else two 32-step passes through the shared divider.
// No new request is taken while a report works through the divider.
// Reset (rst_n, async, active low) clears statistics and error, restores config registers.

module telemetry_frame_validate_summarize (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [tfvs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tfvs_pkg::CFG_DATA_W-1:0] cfg_data,
    tfvs_in_if.sink                              in_ch,
    tfvs_out_if.source                           out_ch
);

    // Controller: sequences a report through average then, unless elapsed time is zero, rate
    // division, and owns both handshakes. Frames and clears are single-cycle commands.
    tfvs_pkg::cmd_t cmd;
    tfvs_pkg::sts_t sts;

    tfvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_func   (in_ch.func),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath: config registers, checks, running statistics, divider and
    // the result register. Result register frees the input side, so frames
    // keep flowing while a report waits to be taken.
    tfvs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire
